// ----- design/rfc_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants of the record format to text converter.
// ---------------------------------------------------------------------------
package rfc_pkg;

    // record formats
    localparam logic [2:0] FMT_UNDEF  = 3'd0;
    localparam logic [2:0] FMT_FIXED  = 3'd1;
    localparam logic [2:0] FMT_VAR    = 3'd2;
    localparam logic [2:0] FMT_VFC    = 3'd3;
    localparam logic [2:0] FMT_STM    = 3'd4;
    localparam logic [2:0] FMT_STMLF  = 3'd5;
    localparam logic [2:0] FMT_STMCR  = 3'd6;
    localparam logic [2:0] FMT_BAD    = 3'd7;

    // configuration register indexes
    localparam logic [2:0] REG_FORMAT     = 3'd0;
    localparam logic [2:0] REG_FORTRAN_CC = 3'd1;
    localparam logic [2:0] REG_FIXED_SIZE = 3'd2;
    localparam logic [2:0] REG_VFC_SIZE   = 3'd3;
    localparam logic [2:0] REG_FILE_SIZE  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // configuration reset values
    localparam logic [2:0]  RST_FORMAT   = FMT_VAR;
    localparam logic [7:0]  RST_VFC_SIZE = 8'd2;

    // characters
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_ONE  = 8'h31;

    localparam logic [30:0] SIZE_MAX31     = 31'h7FFF_FFFF;
    localparam logic [15:0] STREAM_REC_LEN = 16'd512;

    localparam int QUEUE_DEPTH_DEF = 4;

    // length header phase
    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_SKIP   = 2'd2
    } phase_t;

    // one queued work entry: one or two output bytes
    typedef struct packed {
        logic       two;
        logic       err;
        logic [7:0] b0;
        logic [7:0] b1;
    } entry_t;

endpackage
`default_nettype wire

// ----- design/rfc_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfc_front
// Accepts input items, holds configuration and record state, and turns
// each item into zero, one or two output bytes for the queue.
// ---------------------------------------------------------------------------
module rfc_front (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [15:0]                    s_tdata,
    input  wire                            s_tuser,
    input  wire                            cfg_valid,
    input  wire  [rfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [rfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                            q_full,
    output logic                           q_push,
    output rfc_pkg::entry_t                q_entry
);
    import rfc_pkg::*;

    logic [2:0]  format_reg;
    logic        fortran_cc_reg;
    logic [14:0] fixed_size_reg;
    logic [7:0]  vfc_size_reg;
    logic [30:0] file_size_reg;

    logic        file_open_reg, file_open_next;
    logic [30:0] bytes_done_reg, bytes_done_next;
    logic [15:0] rec_rem_reg, rec_rem_next;
    logic [15:0] rec_full_reg, rec_full_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [7:0]  skip_left_reg, skip_left_next;
    logic        chunk_odd_reg, chunk_odd_next;
    logic        pad_reg, pad_next;
    logic        failed_reg, failed_next;

    logic        fire;
    logic [7:0]  din;
    logic        cstart;
    logic [1:0]  n;
    logic [7:0]  o0;
    logic [7:0]  o1;
    logic        err;

    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;
    assign din      = s_tdata[7:0];
    assign cstart   = s_tdata[8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg     <= RST_FORMAT;
            fortran_cc_reg <= 1'b0;
            fixed_size_reg <= '0;
            vfc_size_reg   <= RST_VFC_SIZE;
            file_size_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FORMAT:     format_reg     <= cfg_data[2:0];
                REG_FORTRAN_CC: fortran_cc_reg <= cfg_data[0];
                REG_FIXED_SIZE: fixed_size_reg <= cfg_data[14:0];
                REG_VFC_SIZE:   vfc_size_reg   <= cfg_data[7:0];
                REG_FILE_SIZE:  file_size_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        file_open_next = file_open_reg;
        bytes_done_next = bytes_done_reg;
        rec_rem_next   = rec_rem_reg;
        rec_full_next  = rec_full_reg;
        phase_next     = phase_reg;
        len_low_next   = len_low_reg;
        skip_left_next = skip_left_reg;
        chunk_odd_next = chunk_odd_reg;
        pad_next       = pad_reg;
        failed_next    = failed_reg;
        n   = 2'd0;
        o0  = 8'd0;
        o1  = 8'd0;
        err = 1'b0;

        if (s_tuser) begin
            file_open_next  = 1'b1;
            bytes_done_next = '0;
            rec_rem_next    = '0;
            rec_full_next   = '0;
            phase_next      = PH_LEN_LO;
            len_low_next    = '0;
            skip_left_next  = '0;
            chunk_odd_next  = 1'b0;
            pad_next        = 1'b0;
            failed_next     = 1'b0;
        end else if (file_open_reg && !failed_reg) begin
            if (cstart) begin
                if (pad_reg) begin
                    if (bytes_done_reg != SIZE_MAX31) begin
                        bytes_done_next = bytes_done_reg + 31'd1;
                    end
                    pad_next = 1'b0;
                end
                chunk_odd_next = 1'b0;
            end
            if (bytes_done_next >= file_size_reg) begin
                // beyond file size: dropped
            end else if (format_reg == FMT_UNDEF || format_reg == FMT_BAD) begin
                failed_next = 1'b1;
                err = 1'b1;
                n   = 2'd1;
            end else begin
                bytes_done_next = bytes_done_next + 31'd1;
                chunk_odd_next  = !chunk_odd_next;
                if (pad_next) begin
                    pad_next = 1'b0;
                end else begin
                    case (format_reg)
                        FMT_FIXED: begin
                            if (rec_rem_next == 16'd0) begin
                                rec_rem_next = {1'b0, fixed_size_reg};
                            end
                            rec_rem_next = rec_rem_next - 16'd1;
                            o0 = din;
                            n  = 2'd1;
                        end
                        FMT_VAR, FMT_VFC: begin
                            if (phase_reg == PH_SKIP) begin
                                if (skip_left_next != 8'd0) begin
                                    skip_left_next = skip_left_next - 8'd1;
                                end
                                if (skip_left_next == 8'd0) begin
                                    phase_next = PH_LEN_LO;
                                    if (rec_rem_next == 16'd0 && chunk_odd_next) begin
                                        pad_next = 1'b1;
                                    end
                                end
                            end else if (phase_reg == PH_LEN_HI || rec_rem_next == 16'd0) begin
                                if (phase_reg == PH_LEN_LO) begin
                                    len_low_next = din;
                                    phase_next   = PH_LEN_HI;
                                end else begin
                                    rec_full_next = {din, len_low_reg};
                                    rec_rem_next  = {din, len_low_reg};
                                    phase_next    = PH_LEN_LO;
                                    if (format_reg == FMT_VFC && vfc_size_reg != 8'd0) begin
                                        rec_rem_next   = rec_rem_next - {8'd0, vfc_size_reg};
                                        skip_left_next = vfc_size_reg;
                                        phase_next     = PH_SKIP;
                                    end
                                    if (rec_rem_next == 16'd0) begin
                                        o0 = CH_LF;
                                        n  = 2'd1;
                                        if (phase_next == PH_LEN_LO && chunk_odd_next) begin
                                            pad_next = 1'b1;
                                        end
                                    end
                                end
                            end else begin
                                if (rec_rem_reg == rec_full_reg && fortran_cc_reg) begin
                                    if (din == CH_ZERO) begin
                                        o0 = CH_LF;
                                        n  = 2'd1;
                                    end else if (din == CH_ONE) begin
                                        o0 = CH_FF;
                                        n  = 2'd1;
                                    end
                                end else begin
                                    o0 = din;
                                    n  = 2'd1;
                                end
                                rec_rem_next = rec_rem_reg - 16'd1;
                                if (rec_rem_next == 16'd0) begin
                                    if (n == 2'd0) begin
                                        o0 = CH_LF;
                                    end else begin
                                        o1 = CH_LF;
                                    end
                                    n = n + 2'd1;
                                    if (chunk_odd_next) begin
                                        pad_next = 1'b1;
                                    end
                                end
                            end
                        end
                        FMT_STM, FMT_STMLF: begin
                            if (rec_rem_next == 16'd0) begin
                                rec_rem_next = STREAM_REC_LEN;
                            end
                            rec_rem_next = rec_rem_next - 16'd1;
                            if (din == CH_LF) begin
                                rec_rem_next = 16'd0;
                            end
                            o0 = din;
                            n  = 2'd1;
                        end
                        default: begin
                            o0 = (din == CH_CR) ? CH_LF : din;
                            n  = 2'd1;
                        end
                    endcase
                end
            end
        end
    end

    assign q_push      = fire && (n != 2'd0);
    assign q_entry.two = n[1];
    assign q_entry.err = err;
    assign q_entry.b0  = o0;
    assign q_entry.b1  = o1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_open_reg  <= 1'b0;
            bytes_done_reg <= '0;
            rec_rem_reg    <= '0;
            rec_full_reg   <= '0;
            phase_reg      <= PH_LEN_LO;
            len_low_reg    <= '0;
            skip_left_reg  <= '0;
            chunk_odd_reg  <= 1'b0;
            pad_reg        <= 1'b0;
            failed_reg     <= 1'b0;
        end else if (fire) begin
            file_open_reg  <= file_open_next;
            bytes_done_reg <= bytes_done_next;
            rec_rem_reg    <= rec_rem_next;
            rec_full_reg   <= rec_full_next;
            phase_reg      <= phase_next;
            len_low_reg    <= len_low_next;
            skip_left_reg  <= skip_left_next;
            chunk_odd_reg  <= chunk_odd_next;
            pad_reg        <= pad_next;
            failed_reg     <= failed_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/rfc_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfc_queue
// Short first-word-fall-through queue between front and back.
// ---------------------------------------------------------------------------
module rfc_queue #(
    parameter int DEPTH = rfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  rfc_pkg::entry_t  push_entry,
    output logic             full,
    input  wire              pop,
    output logic             head_valid,
    output rfc_pkg::entry_t  head
);
    import rfc_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ----- design/rfc_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// rfc_back
// Takes queued entries and drives the result stream, one byte per transfer.
// ---------------------------------------------------------------------------
module rfc_back (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              head_valid,
    input  rfc_pkg::entry_t  head,
    output logic             pop,
    output logic             m_tvalid,
    input  wire              m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);
    import rfc_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic       err_reg, err_next;
    logic       second_reg, second_next;
    logic [7:0] held_reg, held_next;
    logic       load_ok;

    assign load_ok = !valid_reg || m_tready;
    assign pop     = load_ok && !second_reg && head_valid;

    always_comb begin
        valid_next  = valid_reg;
        data_next   = data_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        second_next = second_reg;
        held_next   = held_reg;
        if (load_ok) begin
            if (second_reg) begin
                valid_next  = 1'b1;
                data_next   = held_reg;
                last_next   = 1'b1;
                err_next    = 1'b0;
                second_next = 1'b0;
            end else if (head_valid) begin
                valid_next  = 1'b1;
                data_next   = head.b0;
                last_next   = !head.two;
                err_next    = head.err;
                second_next = head.two;
                held_next   = head.b1;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        last_reg <= last_next;
        err_reg  <= err_next;
        held_reg <= held_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule
`default_nettype wire

// ----- design/record_format_to_text_converter.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// record_format_to_text_converter
// Turns the bytes of a record-structured file into a plain text stream.
//
// Input stream s_*: one file byte per transfer; s_tuser high starts a new
// file and clears record state. Result stream m_*: one text byte per
// transfer, m_tlast on the last byte an input produced, m_tuser on an
// error report for an invalid format (m_tdata zero then).
// Configuration: cfg_valid/cfg_index/cfg_data write a register per cycle,
// always ready; write only while no result is outstanding.
// Throughput: one input per cycle while the queue is not full. An input
// that gives two bytes holds the output for both of them; the queue
// between front and back absorbs that. An input's entry is written into
// the queue, then loaded into the output register that drives m_tvalid.
// s_tready drops only while the queue is full, i.e. when the receiver
// stalls long enough for the queue to fill.
// Reset: registers take their defaults (variable format, two control
// bytes), no file is open, queue and output are empty.
// ---------------------------------------------------------------------------
module record_format_to_text_converter #(
    parameter int QUEUE_DEPTH = rfc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [15:0]                     s_tdata,   // data_byte, chunk_start
    input  wire                             s_tuser,   // kind
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [7:0]                      m_tdata,   // out_byte
    output logic                            m_tlast,
    output logic                            m_tuser,   // error
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [rfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire  [rfc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rfc_pkg::*;

    logic   q_push;
    entry_t q_entry;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    entry_t q_head;

    assign cfg_ready = 1'b1;

    rfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    rfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    rfc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue read while empty");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_entry.err |-> !q_entry.two && q_entry.b0 == 8'd0)
        else $error("error report not a single zero byte");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !q_valid && !m_tvalid)
        else $error("queue or output not empty after reset");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_record_format_to_text_converter.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_record_format_to_text_converter
// Self-checking bench for the record format to text converter.
//
// A short directed table covers the formats, the error report, carriage
// control, pad bytes around chunk starts, headers split across chunks,
// short VFC records and the file size limit. Random phases follow, each
// with its own register setting, mostly well-formed variable and VFC
// records with random content plus stream, fixed and noise phases. Every
// accepted input runs through a local model of the converter, and each
// text transfer is checked field by field against the oldest expected one.
// The sender works in bursts, the receiver stalls on its own pattern, and
// one phase holds the receiver off long enough to back up the input.
// ---------------------------------------------------------------------------
module tb_record_format_to_text_converter;
    import rfc_pkg::*;

    localparam int          RANDOM_ITEMS = 700;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          MAX_PRINTED  = 40;
    localparam logic [2:0]  REG_SPARE    = 3'd5;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic       err;
    } text_beat_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_CHECK
    } row_op_t;

    typedef struct {
        row_op_t     op;
        logic [2:0]  idx;
        logic [30:0] val;
        logic        kind;
        logic [7:0]  data;
        logic        cs;
        text_beat_t  want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [15:0]            s_tdata   = '0;   // data_byte, chunk_start
    logic                   s_tuser   = 1'b0; // kind
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;          // out_byte
    logic                   m_tlast;
    logic                   m_tuser;          // error
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // converter model: register copies
    logic [2:0]  cfg_fmt   = RST_FORMAT;
    logic        cfg_ftn   = 1'b0;
    logic [14:0] cfg_fixed = '0;
    logic [7:0]  cfg_vfc   = RST_VFC_SIZE;
    logic [30:0] cfg_fsize = '0;

    // converter model: file and record state
    logic        p_open   = 1'b0;
    logic [30:0] p_done   = '0;
    logic [15:0] p_left   = '0;
    logic [15:0] p_full   = '0;
    phase_t      p_phase  = PH_LEN_LO;
    logic [7:0]  p_lenlo  = '0;
    logic [7:0]  p_skip   = '0;
    logic        p_odd    = 1'b0;
    logic        p_pad    = 1'b0;
    logic        p_failed = 1'b0;

    text_beat_t  pred_out [2];
    int          pred_n;
    text_beat_t  expected_text [$];
    stim_row_t   stim_table [$];

    int          items_sent     = 0;
    int          chunk_pos      = 0;
    int          burst_left     = 0;
    bit          hold_req       = 1'b0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    record_format_to_text_converter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transfers outstanding",
                     cycle_count, expected_text.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void add_text(input logic [7:0] c);
        pred_out[pred_n] = '{c, 1'b0, 1'b0};
        pred_n++;
    endfunction

    // expected text for one input transfer, left in pred_out[0:pred_n-1]
    function automatic void predict_text(input logic k, input logic [7:0] b, input logic cs);
        pred_n = 0;
        if (k) begin
            p_open   = 1'b1;
            p_done   = '0;
            p_left   = '0;
            p_full   = '0;
            p_phase  = PH_LEN_LO;
            p_lenlo  = '0;
            p_skip   = '0;
            p_odd    = 1'b0;
            p_pad    = 1'b0;
            p_failed = 1'b0;
            return;
        end
        if (!p_open || p_failed)
            return;
        if (cs) begin
            if (p_pad) begin
                if (p_done < SIZE_MAX31)
                    p_done = p_done + 1'b1;
                p_pad = 1'b0;
            end
            p_odd = 1'b0;
        end
        if (p_done >= cfg_fsize)
            return;
        if (cfg_fmt == FMT_UNDEF || cfg_fmt == FMT_BAD) begin
            p_failed    = 1'b1;
            pred_out[0] = '{8'h00, 1'b1, 1'b1};
            pred_n      = 1;
            return;
        end
        p_done = p_done + 1'b1;
        p_odd  = !p_odd;
        if (p_pad) begin
            p_pad = 1'b0;
            return;
        end
        case (cfg_fmt)
            FMT_FIXED: begin
                if (p_left == 0)
                    p_left = {1'b0, cfg_fixed};
                p_left = p_left - 1'b1;
                add_text(b);
            end
            FMT_VAR, FMT_VFC: begin
                if (p_phase == PH_SKIP) begin
                    if (p_skip != 0)
                        p_skip = p_skip - 1'b1;
                    if (p_skip == 0) begin
                        p_phase = PH_LEN_LO;
                        if (p_left == 0 && p_odd)
                            p_pad = 1'b1;
                    end
                end else if (p_phase == PH_LEN_HI || p_left == 0) begin
                    if (p_phase == PH_LEN_LO) begin
                        p_lenlo = b;
                        p_phase = PH_LEN_HI;
                    end else begin
                        p_full  = {b, p_lenlo};
                        p_left  = p_full;
                        p_phase = PH_LEN_LO;
                        if (cfg_fmt == FMT_VFC && cfg_vfc != 0) begin
                            p_left  = p_left - {8'h00, cfg_vfc};
                            p_skip  = cfg_vfc;
                            p_phase = PH_SKIP;
                        end
                        if (p_left == 0) begin
                            add_text(CH_LF);
                            if (p_phase == PH_LEN_LO && p_odd)
                                p_pad = 1'b1;
                        end
                    end
                end else begin
                    if (p_left == p_full && cfg_ftn) begin
                        if (b == CH_ZERO)
                            add_text(CH_LF);
                        else if (b == CH_ONE)
                            add_text(CH_FF);
                    end else begin
                        add_text(b);
                    end
                    p_left = p_left - 1'b1;
                    if (p_left == 0) begin
                        add_text(CH_LF);
                        if (p_odd)
                            p_pad = 1'b1;
                    end
                end
            end
            FMT_STM, FMT_STMLF: begin
                if (p_left == 0)
                    p_left = STREAM_REC_LEN;
                p_left = p_left - 1'b1;
                if (b == CH_LF)
                    p_left = '0;
                add_text(b);
            end
            default: begin
                add_text(b == CH_CR ? CH_LF : b);
            end
        endcase
        if (pred_n > 0)
            pred_out[pred_n-1].last = 1'b1;
    endfunction

    always @(posedge aclk) begin : text_monitor
        text_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_text.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, data %h last %b error %b",
                                        m_tdata, m_tlast, m_tuser));
            end else begin
                want = expected_text.pop_front();
                if (m_tdata !== want.text)
                    note_mismatch($sformatf("out_byte %h, expected %h", m_tdata, want.text));
                if (m_tlast !== want.last)
                    note_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
                if (m_tuser !== want.err)
                    note_mismatch($sformatf("error %b, expected %b", m_tuser, want.err));
            end
        end
    end

    // receiver: stall pattern that changes at random, plus a long hold-off on request
    initial begin : text_receiver
        int mode;
        int mode_left;
        int hold_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    task automatic send_item(input logic k, input logic [7:0] d, input logic cs,
                             input bit use_model);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'd0, cs, d};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        predict_text(k, d, cs);
        if (use_model)
            for (int i = 0; i < pred_n; i++)
                expected_text.push_back(pred_out[i]);
    endtask

    task automatic put_byte(input logic [7:0] d, input logic cs);
        if (cs)
            chunk_pos = 0;
        send_item(1'b0, d, cs, 1'b1);
        chunk_pos++;
    endtask

    task automatic new_file();
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        chunk_pos = 0;
    endtask

    // sender pauses until every expected transfer is back and the pipe is empty
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FORMAT:     cfg_fmt   = val[2:0];
            REG_FORTRAN_CC: cfg_ftn   = val[0];
            REG_FIXED_SIZE: cfg_fixed = val[14:0];
            REG_VFC_SIZE:   cfg_vfc   = val[7:0];
            REG_FILE_SIZE:  cfg_fsize = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic rare_start();
        return ($urandom_range(0, 15) == 0);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 19))
            0, 1: return CH_LF;
            2, 3: return CH_CR;
            4:    return CH_ZERO;
            5:    return CH_ONE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one length-prefixed record with random body, VFC control bytes included
    task automatic put_record(input logic first_cs);
        int          total;
        int          body;
        logic [15:0] len;
        if (cfg_fmt == FMT_VFC) begin
            body  = $urandom_range(0, 10);
            total = cfg_vfc + body;
            if (cfg_vfc != 0 && $urandom_range(0, 29) == 0)
                total = $urandom_range(0, cfg_vfc - 1);
        end else begin
            total = $urandom_range(0, 12);
            body  = total;
        end
        len = 16'(total);
        put_byte(len[7:0], first_cs);
        put_byte(len[15:8], rare_start());
        if (cfg_fmt == FMT_VFC)
            for (int i = 0; i < cfg_vfc; i++)
                put_byte(8'($urandom_range(0, 255)), rare_start());
        if (cfg_fmt == FMT_VFC && total < cfg_vfc) begin
            // wrapped length: the record would run for ages, so open a new file
            for (int i = 0; i < 6; i++)
                put_byte(pick_byte(), rare_start());
            new_file();
        end else begin
            for (int i = 0; i < body; i++)
                put_byte(pick_byte(), rare_start());
        end
    endtask

    task automatic run_phase(input bit pressure);
        logic [2:0]  fmt;
        logic [30:0] fsize;
        logic        cs_next;
        int          goal;
        wait_idle();
        case ($urandom_range(0, 19))
            0, 1:                fmt = FMT_FIXED;
            2:                   fmt = FMT_STM;
            3:                   fmt = FMT_STMLF;
            4, 5:                fmt = FMT_STMCR;
            6:                   fmt = $urandom_range(0, 1) ? FMT_BAD : FMT_UNDEF;
            7, 8, 9, 10, 11, 12: fmt = FMT_VAR;
            default:             fmt = FMT_VFC;
        endcase
        if (pressure)
            fmt = FMT_STM;
        write_reg(REG_FORMAT, 31'(fmt));
        if ($urandom_range(0, 1))
            write_reg(REG_FORTRAN_CC, 31'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 11))
                0:       write_reg(REG_VFC_SIZE, 31'd0);
                1:       write_reg(REG_VFC_SIZE, 31'd255);
                default: write_reg(REG_VFC_SIZE, 31'($urandom_range(1, 4)));
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       write_reg(REG_FIXED_SIZE, 31'd0);
                1:       write_reg(REG_FIXED_SIZE, 31'h7FFF);
                default: write_reg(REG_FIXED_SIZE, 31'($urandom_range(1, 40)));
            endcase
        end
        case ($urandom_range(0, 9))
            0:       fsize = 31'($urandom_range(0, 30));
            1:       fsize = 31'($urandom);
            default: fsize = SIZE_MAX31;
        endcase
        if (pressure)
            fsize = SIZE_MAX31;
        write_reg(REG_FILE_SIZE, fsize);
        if ($urandom_range(0, 19) == 0)
            write_reg(REG_SPARE, 31'($urandom));
        if (pressure || $urandom_range(0, 4) != 0)
            new_file();
        if (pressure)
            hold_req = 1'b1;
        goal = items_sent + $urandom_range(15, 45);
        if ((fmt == FMT_VAR || fmt == FMT_VFC) && $urandom_range(0, 6) != 0) begin
            cs_next = rare_start();
            while (items_sent < goal) begin
                put_record(cs_next);
                cs_next = ($urandom_range(0, 5) == 0);
                if (!cs_next && chunk_pos % 2 == 1)
                    put_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        end else if (fmt == FMT_VAR || fmt == FMT_VFC || fmt == FMT_UNDEF || fmt == FMT_BAD) begin
            while (items_sent < goal) begin
                if ($urandom_range(0, 29) == 0)
                    new_file();
                else
                    put_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end
        end else begin
            while (items_sent < goal)
                put_byte(pick_byte(), rare_start());
        end
    endtask

    function automatic void cfg_row(input logic [2:0] idx, input logic [30:0] val);
        stim_table.push_back('{ROW_CFG, idx, val, 1'b0, 8'h00, 1'b0, '0});
    endfunction

    function automatic void item_row(input logic k, input logic [7:0] d, input logic cs);
        stim_table.push_back('{ROW_ITEM, REG_FORMAT, '0, k, d, cs, '0});
    endfunction

    function automatic void check_row(input logic k, input logic [7:0] d, input logic cs,
                                      input logic [7:0] t, input logic l, input logic e);
        stim_table.push_back('{ROW_CHECK, REG_FORMAT, '0, k, d, cs, '{t, l, e}});
    endfunction

    initial begin : stimulus
        int random_goal;
        int phase_no;

        // data with no file open, then a file with size limit zero
        item_row(1'b0, 8'h5A, 1'b1);
        item_row(1'b1, 8'hFF, 1'b1);
        item_row(1'b0, 8'h41, 1'b1);
        cfg_row(REG_FILE_SIZE, SIZE_MAX31);
        // invalid and undefined formats report once
        cfg_row(REG_FORMAT, 31'(FMT_BAD));
        check_row(1'b0, 8'h55, 1'b1, 8'h00, 1'b1, 1'b1);
        item_row(1'b0, 8'hAA, 1'b0);
        cfg_row(REG_FORMAT, 31'(FMT_UNDEF));
        item_row(1'b1, 8'h00, 1'b0);
        check_row(1'b0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1);
        // stream-CR, fixed and stream pass-through
        cfg_row(REG_FORMAT, 31'(FMT_STMCR));
        item_row(1'b1, 8'h00, 1'b0);
        check_row(1'b0, CH_CR, 1'b1, CH_LF, 1'b1, 1'b0);
        check_row(1'b0, 8'hFF, 1'b0, 8'hFF, 1'b1, 1'b0);
        cfg_row(REG_FORMAT, 31'(FMT_FIXED));
        cfg_row(REG_FIXED_SIZE, 31'h7FFF);
        check_row(1'b0, CH_CR, 1'b0, CH_CR, 1'b1, 1'b0);
        cfg_row(REG_FORMAT, 31'(FMT_STM));
        check_row(1'b0, CH_LF, 1'b1, CH_LF, 1'b1, 1'b0);
        // variable records with carriage control, pads and a ten byte file
        cfg_row(REG_FORMAT, 31'(FMT_VAR));
        cfg_row(REG_FORTRAN_CC, 31'd1);
        cfg_row(REG_FILE_SIZE, 31'd10);
        item_row(1'b1, 8'h00, 1'b0);
        item_row(1'b0, 8'h01, 1'b1);
        item_row(1'b0, 8'h00, 1'b0);
        item_row(1'b0, CH_ZERO, 1'b0);
        item_row(1'b0, 8'h99, 1'b0);
        item_row(1'b0, 8'h02, 1'b0);
        item_row(1'b0, 8'h00, 1'b1);
        item_row(1'b0, CH_ONE, 1'b0);
        item_row(1'b0, 8'h43, 1'b0);
        item_row(1'b0, 8'h00, 1'b1);
        item_row(1'b0, 8'h00, 1'b0);
        // vfc without control bytes, then a record shorter than its control bytes
        cfg_row(REG_FORTRAN_CC, 31'd0);
        cfg_row(REG_FORMAT, 31'(FMT_VFC));
        cfg_row(REG_VFC_SIZE, 31'd0);
        cfg_row(REG_FILE_SIZE, SIZE_MAX31);
        item_row(1'b1, 8'h00, 1'b0);
        item_row(1'b0, 8'h01, 1'b1);
        item_row(1'b0, 8'h00, 1'b0);
        item_row(1'b0, 8'h5A, 1'b0);
        cfg_row(REG_VFC_SIZE, 31'd2);
        cfg_row(REG_SPARE, SIZE_MAX31);
        item_row(1'b0, 8'h01, 1'b1);
        item_row(1'b0, 8'h00, 1'b0);
        item_row(1'b0, 8'hC3, 1'b0);
        item_row(1'b0, 8'h3C, 1'b0);
        item_row(1'b0, 8'h51, 1'b0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_table[r]) begin
            case (stim_table[r].op)
                ROW_CFG: begin
                    wait_idle();
                    write_reg(stim_table[r].idx, stim_table[r].val);
                end
                ROW_ITEM: begin
                    send_item(stim_table[r].kind, stim_table[r].data, stim_table[r].cs, 1'b1);
                end
                default: begin
                    send_item(stim_table[r].kind, stim_table[r].data, stim_table[r].cs, 1'b0);
                    expected_text.push_back(stim_table[r].want);
                end
            endcase
        end

        random_goal = items_sent + RANDOM_ITEMS;
        phase_no    = 0;
        while (items_sent < random_goal) begin
            run_phase(phase_no == 2);
            phase_no++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
design/rfc_pkg.sv
design/rfc_front.sv
design/rfc_queue.sv
design/rfc_back.sv
design/record_format_to_text_converter.sv
sim/tb_record_format_to_text_converter.sv
